FILE: design/frad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frad_pkg: shared types and constants of the averaging decimator
// Field widths, scaling constants, the divider state type and the structs
// that pass between the window accumulator and the divider.
// ----------------------------------------------------------------------------
package frad_pkg;

	localparam int SAMPLE_W = 16;
	localparam int PCM_W = 16;
	localparam int RATIO_W = 24;
	localparam int PHASE_W = 25;
	localparam int SUM_W = 25;
	localparam int COUNT_W = 9;
	localparam int QUO_W = 15;
	localparam int STEP_W = 4;
	localparam int DVS_W = COUNT_W + QUO_W;
	localparam int SCALE_W = 15;
	localparam int PROD_W = SUM_W + SCALE_W;

	// The doubled mean scaled to PCM is sum * 65534 / (count * 32768),
	// which is sum * 32767 / (count * 16384).
	localparam logic [SCALE_W-1:0] PCM_SCALE = 15'd32767;
	localparam int SCALE_SHIFT = 14;

	localparam int DEF_RATIO_FRAC_BITS = 16;
	localparam longint NOMINAL_IN_RATE = 1789773;
	localparam longint OUTPUT_RATE = 44100;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_MUL,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

	typedef struct packed {
		logic                      start;
		logic signed [SUM_W-1:0]   sum;
		logic [COUNT_W-1:0]        count;
	} win_req_t;

	typedef struct packed {
		logic busy;
		logic res_valid;
	} div_stat_t;

endpackage

FILE: design/frad_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frad_window: window accumulator and phase tracker
// Adds each sample to a saturating window sum, counts it, advances the phase
// and closes the window when the phase reaches the decimation ratio.
// ----------------------------------------------------------------------------
module frad_window import frad_pkg::*; #(
	parameter int RATIO_FRAC_BITS = DEF_RATIO_FRAC_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [RATIO_W-1:0]         ratio,
	output win_req_t                   win
);

	localparam logic [PHASE_W-1:0] ONE_STEP = PHASE_W'(1) << RATIO_FRAC_BITS;
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	logic [PHASE_W-1:0]      phase_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [COUNT_W-1:0]      count_q;

	logic signed [SUM_W:0]   sum_ext;
	logic signed [SUM_W-1:0] sum_new;
	logic [COUNT_W-1:0]      count_new;
	logic [PHASE_W-1:0]      phase_inc;
	logic [PHASE_W-1:0]      ratio_ext;
	logic [PHASE_W-1:0]      ratio_eff;
	logic                    emit;

	always_comb begin
		sum_ext = {sum_q[SUM_W-1], sum_q}
			+ {{(SUM_W + 1 - SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			sum_new = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_new = sum_ext[SUM_W-1:0];
		end
		count_new = (count_q == {COUNT_W{1'b1}}) ? count_q : count_q + 1'b1;
		phase_inc = phase_q + ONE_STEP;
		ratio_ext = {{(PHASE_W - RATIO_W){1'b0}}, ratio};
		ratio_eff = (ratio_ext < ONE_STEP) ? ONE_STEP : ratio_ext;
		emit = (phase_inc >= ratio_eff);
		win.start = accept && emit;
		win.sum = sum_new;
		win.count = count_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			sum_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (emit) begin
				phase_q <= phase_inc - ratio_eff;
				sum_q <= '0;
				count_q <= '0;
			end else begin
				phase_q <= phase_inc;
				sum_q <= sum_new;
				count_q <= count_new;
			end
		end
	end

endmodule

FILE: design/frad_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frad_div: iterative mean divider
// Scales the window magnitude, then finds the quotient by count one bit per
// cycle with a shared compare and subtract, saturating at full scale.
// ----------------------------------------------------------------------------
module frad_div import frad_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  win_req_t                win,
	input  logic                    res_take,
	output div_stat_t               stat,
	output logic signed [PCM_W-1:0] res_pcm
);

	div_state_t state_q;
	div_state_t state_nx;

	logic               neg_q;
	logic               sat_q;
	logic [SUM_W-1:0]   mag_q;
	logic [SUM_W-1:0]   rem_q;
	logic [DVS_W-1:0]   dvs_q;
	logic [QUO_W-1:0]   quo_q;
	logic [STEP_W-1:0]  step_q;

	logic [PROD_W-1:0]  prod;
	logic [SUM_W-1:0]   dvs_ext;
	logic               ge;
	logic               first;
	logic [QUO_W-1:0]   mag_res;

	always_comb begin
		prod = PROD_W'(mag_q) * PROD_W'(PCM_SCALE);
		dvs_ext = {{(SUM_W - DVS_W){1'b0}}, dvs_q};
		ge = (rem_q >= dvs_ext);
		first = (step_q == STEP_W'(QUO_W));
		mag_res = sat_q ? {QUO_W{1'b1}} : quo_q;
		res_pcm = neg_q ? -{1'b0, mag_res} : {1'b0, mag_res};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		stat.busy = 1'b1;
		stat.res_valid = 1'b0;
		unique case (state_q)
			DIV_IDLE: begin
				stat.busy = 1'b0;
				if (win.start) begin
					state_nx = DIV_MUL;
				end
			end
			DIV_MUL: begin
				state_nx = DIV_RUN;
			end
			DIV_RUN: begin
				if ((first && ge) || step_q == '0) begin
					state_nx = DIV_DONE;
				end
			end
			DIV_DONE: begin
				stat.res_valid = 1'b1;
				if (res_take) begin
					state_nx = DIV_IDLE;
				end
			end
			default: begin
				state_nx = DIV_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			DIV_IDLE: begin
				if (win.start) begin
					neg_q <= win.sum[SUM_W-1];
					mag_q <= win.sum[SUM_W-1] ? SUM_W'(-win.sum) : SUM_W'(win.sum);
					dvs_q <= {win.count, {QUO_W{1'b0}}};
					step_q <= STEP_W'(QUO_W);
					quo_q <= '0;
					sat_q <= 1'b0;
				end
			end
			DIV_MUL: begin
				rem_q <= prod[SCALE_SHIFT +: SUM_W];
			end
			DIV_RUN: begin
				if (first) begin
					sat_q <= ge;
				end else begin
					quo_q <= {quo_q[QUO_W-2:0], ge};
					if (ge) begin
						rem_q <= rem_q - dvs_ext;
					end
				end
				dvs_q <= dvs_q >> 1;
				step_q <= step_q - 1'b1;
			end
			DIV_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: design/fractional_ratio_averaging_decimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_ratio_averaging_decimator: boxcar averaging decimator
// Averages Q1.15 samples over windows set by a Q8.16 ratio and emits the
// doubled, saturated window mean as 16-bit PCM.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  sample (16 bit signed)
// output    out        out_valid/out_stall  pcm_sample (16 bit signed)
// config    in         cfg_valid/cfg_ready  cfg_data (24 bit ratio)
//
// A request that does not close a window is only accumulated and does not
// stall the input. A request that closes a window is accumulated, then goes
// through the scaling multiply and the bit-serial divider with its single
// compare and subtract unit; input stalls until the divider result is taken.
// Reset loads the nominal ratio and clears the phase, sum and count.
// A finished result waits in the output register while new input is taken.
// ----------------------------------------------------------------------------
module fractional_ratio_averaging_decimator import frad_pkg::*; #(
	parameter int RATIO_FRAC_BITS = DEF_RATIO_FRAC_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [PCM_W-1:0]    pcm_sample,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [RATIO_W-1:0]         cfg_data
);

	localparam logic [RATIO_W-1:0] RATIO_RESET =
		RATIO_W'((64'(NOMINAL_IN_RATE) << RATIO_FRAC_BITS) / OUTPUT_RATE);

	logic [RATIO_W-1:0]      ratio_q;
	logic                    out_valid_q;
	logic signed [PCM_W-1:0] pcm_q;

	logic                    in_accept;
	logic                    res_take;
	win_req_t                win;
	div_stat_t               div_stat;
	logic signed [PCM_W-1:0] res_pcm;

	assign cfg_ready = 1'b1;
	assign in_stall = div_stat.busy;
	assign in_accept = in_valid && !in_stall;
	assign res_take = div_stat.res_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign pcm_sample = pcm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ratio_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			pcm_q <= res_pcm;
		end
	end

	frad_window #(
		.RATIO_FRAC_BITS(RATIO_FRAC_BITS)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (in_accept),
		.sample (sample),
		.ratio  (ratio_q),
		.win    (win)
	);

	frad_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.win      (win),
		.res_take (res_take),
		.stat     (div_stat),
		.res_pcm  (res_pcm)
	);

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		win.start |-> !div_stat.busy)
		else $error("window closed while the divider was busy");

	a_pcm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pcm_sample != 16'sh8000)
		else $error("result outside the symmetric PCM range");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.res_valid && !res_take |=> div_stat.res_valid && $stable(res_pcm))
		else $error("divider result lost before it was taken");

endmodule
